>>> sv/permutation_swap_difference_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the permutation swap difference block.
// Checks are active in simulation and compile to nothing in synthesis.
// ---------------------------------------------------------------------------
`ifndef PERMUTATION_SWAP_DIFFERENCE_DEFINES_SVH
`define PERMUTATION_SWAP_DIFFERENCE_DEFINES_SVH

`ifndef SYNTHESIS

// Concurrent check sampled on the rising clock, switched off during reset.
`define PSD_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check sampled on the rising clock, also during reset.
`define PSD_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define PSD_ASSERT(name, clk, rst_n, prop, msg)
`define PSD_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

>>> sv/psd_pkg.sv
// ---------------------------------------------------------------------------
// psd_pkg
// Types and constants shared by the permutation swap difference block and
// its channel interfaces.
// ---------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

    // Fixed widths of the beat fields.
    localparam int unsigned PSD_IN_LABEL_BITS = 16;
    localparam int unsigned PSD_POS_BITS      = 5;

    // At most this many transpositions are reported per run.
    localparam logic [PSD_POS_BITS-1:0] PSD_MAX_RESULTS = 5'd31;

    typedef struct packed {
        logic [PSD_IN_LABEL_BITS-1:0] own_label;
        logic [PSD_IN_LABEL_BITS-1:0] ref_label;
        logic                         last_item;
    } t_in_item;

    typedef struct packed {
        logic [PSD_POS_BITS-1:0] swap_first;
        logic [PSD_POS_BITS-1:0] swap_second;
        logic                    no_swaps;
        logic                    run_end;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RDI,
        S_LATCH,
        S_SCAN,
        S_WRI,
        S_WRJ,
        S_EMIT,
        S_NEXT,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

>>> sv/psd_if.sv
// ---------------------------------------------------------------------------
// psd_if
// Valid/ready channels carrying input and result beats of the permutation
// swap difference block.
// ---------------------------------------------------------------------------
`default_nettype none

interface psd_in_if;
    import psd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psd_out_if;
    import psd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> sv/permutation_swap_difference.sv
// Beats are loaded while the sequencer is idle; after the last beat a run over n positions
// visits each position in turn, and a stalled result channel can hold it up.
// Per position, S_RDI and S_LATCH read it, S_SCAN compares working memory entries at one
// compare per cycle through its single read port, and S_WRI, S_WRJ, S_EMIT and S_NEXT
// swap and report. Reset clears the fill count, the sequencer and the output valid flag
// and holds ready low; memory is not reset and every entry used is written before it is read.
// ---------------------------------------------------------------------------
// permutation_swap_difference
// Expresses the difference between two label sequences as a list of
// transpositions, using two single-port-write label memories.
// ---------------------------------------------------------------------------
`default_nettype none

`include "permutation_swap_difference_defines.svh"

module permutation_swap_difference #(
    parameter int unsigned MAX_LEN    = 32,
    parameter int unsigned LABEL_BITS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    psd_in_if.sink    i_in,
    psd_out_if.source o_out
);
    import psd_pkg::*;

    localparam int unsigned IW = $clog2(MAX_LEN);
    localparam int unsigned CW = $clog2(MAX_LEN + 1);

    // Label memories.
    logic [LABEL_BITS-1:0] own_mem  [MAX_LEN];
    logic [LABEL_BITS-1:0] work_mem [MAX_LEN];

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [IW-1:0]         r_i, n_i;
    logic [IW-1:0]         r_j, n_j;
    logic [LABEL_BITS-1:0] r_want, n_want;
    logic [LABEL_BITS-1:0] r_wi, n_wi;
    logic [LABEL_BITS-1:0] r_own_q, r_work_q;
    logic [PSD_POS_BITS-1:0] r_count, n_count;
    logic [PSD_POS_BITS-1:0] r_pend_first, n_pend_first;
    logic [PSD_POS_BITS-1:0] r_pend_second, n_pend_second;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  own_we;
    logic                  work_we;
    logic [IW-1:0]         wr_addr;
    logic [IW-1:0]         rd_addr;
    logic [LABEL_BITS-1:0] work_wdata;
    logic [LABEL_BITS-1:0] own_in, ref_in;
    logic [LABEL_BITS+PSD_IN_LABEL_BITS-1:0] own_ext, ref_ext;
    logic [IW+PSD_POS_BITS-1:0] i_ext, j_ext;
    logic                  push;
    t_out_item             push_item;
    logic                  out_free;
    logic                  in_fire;
    logic                  hit;
    logic                  j_last;
    logic                  i_last;
    logic                  has_room;

    assign own_ext  = {{LABEL_BITS{1'b0}}, i_in.data.own_label};
    assign ref_ext  = {{LABEL_BITS{1'b0}}, i_in.data.ref_label};
    assign own_in   = own_ext[LABEL_BITS-1:0];
    assign ref_in   = ref_ext[LABEL_BITS-1:0];
    assign i_ext    = {{PSD_POS_BITS{1'b0}}, r_i};
    assign j_ext    = {{PSD_POS_BITS{1'b0}}, r_j};

    assign i_in.ready  = i_rst_n && (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign out_free    = !r_out_valid || o_out.ready;

    assign has_room = (r_cnt < CW'(MAX_LEN));
    assign hit      = (r_work_q == r_want);
    assign j_last   = (CW'(r_j) == r_cnt - CW'(1));
    assign i_last   = (CW'(r_i) == r_cnt - CW'(1));

    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_i           = r_i;
        n_j           = r_j;
        n_want        = r_want;
        n_wi          = r_wi;
        n_count       = r_count;
        n_pend_first  = r_pend_first;
        n_pend_second = r_pend_second;
        own_we        = 1'b0;
        work_we       = 1'b0;
        wr_addr       = r_cnt[IW-1:0];
        work_wdata    = ref_in;
        rd_addr       = r_i;
        push          = 1'b0;
        push_item     = '{swap_first: r_pend_first, swap_second: r_pend_second,
                          no_swaps: 1'b0, run_end: 1'b0};

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (has_room) begin
                        own_we  = 1'b1;
                        work_we = 1'b1;
                        n_cnt   = r_cnt + CW'(1);
                    end
                    if (i_in.data.last_item) begin
                        n_i     = '0;
                        n_count = '0;
                        n_state = S_RDI;
                    end
                end
            end
            S_RDI: begin
                rd_addr = r_i;
                n_state = S_LATCH;
            end
            S_LATCH: begin
                // Own label and working entry of position i are back; start the scan.
                n_want  = r_own_q;
                n_wi    = r_work_q;
                rd_addr = '0;
                n_j     = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // r_work_q holds entry r_j; the next entry is already being read.
                rd_addr = r_j + IW'(1);
                priority if (hit) begin
                    n_state = (r_j == r_i) ? S_NEXT : S_WRI;
                end else if (j_last) begin
                    n_state = S_NEXT;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            S_WRI: begin
                // The matched entry equals the wanted label, so it moves to i.
                work_we    = 1'b1;
                wr_addr    = r_i;
                work_wdata = r_want;
                n_state    = S_WRJ;
            end
            S_WRJ: begin
                work_we    = 1'b1;
                wr_addr    = r_j;
                work_wdata = r_wi;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                // A pair is held back one step so that the last one can carry run_end.
                if (r_count == PSD_MAX_RESULTS) begin
                    n_state = S_NEXT;
                end else if (r_count == '0 || out_free) begin
                    push          = (r_count != '0);
                    n_pend_first  = i_ext[PSD_POS_BITS-1:0];
                    n_pend_second = j_ext[PSD_POS_BITS-1:0];
                    n_count       = r_count + PSD_POS_BITS'(1);
                    n_state       = S_NEXT;
                end
            end
            S_NEXT: begin
                if (i_last) begin
                    n_state = S_DONE;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = S_RDI;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    push = 1'b1;
                    if (r_count == '0) begin
                        push_item = '{swap_first: '0, swap_second: '0,
                                      no_swaps: 1'b1, run_end: 1'b1};
                    end else begin
                        push_item.run_end = 1'b1;
                    end
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (push) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i           <= n_i;
        r_j           <= n_j;
        r_want        <= n_want;
        r_wi          <= n_wi;
        r_count       <= n_count;
        r_pend_first  <= n_pend_first;
        r_pend_second <= n_pend_second;
        if (push) begin
            r_out <= push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (own_we) begin
            own_mem[wr_addr] <= own_in;
        end
        r_own_q <= own_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (work_we) begin
            work_mem[wr_addr] <= work_wdata;
        end
        r_work_q <= work_mem[rd_addr];
    end

    `PSD_ASSERT(a_swap_follows_hit, i_clk, i_rst_n,
        (r_state == S_SCAN && hit && r_j != r_i) |=> (r_state == S_WRI),
        "match at another position must start a swap")
    `PSD_ASSERT(a_scan_in_range, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> (CW'(r_j) < r_cnt),
        "scan index beyond stored positions")
    `PSD_ASSERT(a_empty_is_final, i_clk, i_rst_n,
        (r_out_valid && r_out.no_swaps) |-> r_out.run_end,
        "empty result must close the run")
    `PSD_ASSERT(a_done_clears, i_clk, i_rst_n,
        (r_state == S_DONE && out_free) |=>
            (r_state == S_IDLE && r_cnt == '0 && r_out_valid && r_out.run_end),
        "run end must flush and clear the store")

endmodule

`default_nettype wire
